// ----- design/sfa_pkg.sv -----
// ----------------------------------------------------------------------------
// sfa_pkg
// Shared widths, register indexes and defaults for the separation force
// accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

package sfa_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int POS_W         = 32;
  localparam int REG_W         = 31;
  localparam int SUM_W         = 40;
  localparam int CFG_AW        = 2;

  localparam logic [CFG_AW-1:0] REG_AVOID = 2'd0;
  localparam logic [CFG_AW-1:0] REG_NBR   = 2'd1;
  localparam logic [CFG_AW-1:0] REG_SEPW  = 2'd2;
  localparam logic [CFG_AW-1:0] REG_MAXA  = 2'd3;

endpackage

`default_nettype wire

// ----- design/separation_force_accumulator_core.sv -----
// ----------------------------------------------------------------------------
// separation_force_accumulator_core
// Boids separation force: accumulates weighted unit offsets of neighbours and
// emits the gain-scaled, norm-clamped acceleration on the last word.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready): one word per candidate neighbour, own
//   and neighbour position in signed fixed point, plus is_self and last_item.
//   Output channel (out_valid/out_ready): one acceleration word per query,
//   produced after the word flagged last_item.
//   Config port: cfg_we/cfg_addr/cfg_wdata, write only, while the block idles.
//   Work per word, all on one shared 32x32 multiplier, one 32-step restoring
//   square root unit and one 32-step restoring divider:
//     skipped neighbour: filtered at the input, dropped after the squares at
//     zero offset, or after the root when it shows it out of range or of
//     zero weight; contributing neighbour: accept, squares, root, select,
//     weight divide, weight square, then three per-axis divides.
//   A last word adds scaling, the shift search and the output load, plus a
//   root and three divides when the norm clamp fires.
//   in_ready is high only while the sequencer idles. A finished result sits
//   in the output register; a new word is taken meanwhile, and only the next
//   result waits for the receiver. Reset restores the register defaults and
//   clears the accumulators; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module separation_force_accumulator_core #(
  parameter int FRAC_BITS = sfa_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [sfa_pkg::POS_W-1:0]    in_self_x,
  input  logic signed [sfa_pkg::POS_W-1:0]    in_self_y,
  input  logic signed [sfa_pkg::POS_W-1:0]    in_self_z,
  input  logic signed [sfa_pkg::POS_W-1:0]    in_other_x,
  input  logic signed [sfa_pkg::POS_W-1:0]    in_other_y,
  input  logic signed [sfa_pkg::POS_W-1:0]    in_other_z,
  input  logic                                in_is_self,
  input  logic                                in_last_item,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [sfa_pkg::POS_W-1:0]    out_accel_x,
  output logic signed [sfa_pkg::POS_W-1:0]    out_accel_y,
  output logic signed [sfa_pkg::POS_W-1:0]    out_accel_z,
  input  logic                                cfg_we,
  input  logic [sfa_pkg::CFG_AW-1:0]          cfg_addr,
  input  logic [sfa_pkg::REG_W-1:0]           cfg_wdata
);
  import sfa_pkg::*;

  localparam int W_W = FRAC_BITS + 3;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_SQ   = 4'd1;
  localparam logic [3:0] ST_RT   = 4'd2;
  localparam logic [3:0] ST_WSEL = 4'd3;
  localparam logic [3:0] ST_WDIV = 4'd4;
  localparam logic [3:0] ST_WSQ  = 4'd5;
  localparam logic [3:0] ST_CMUL = 4'd6;
  localparam logic [3:0] ST_CDIV = 4'd7;
  localparam logic [3:0] ST_SCL  = 4'd8;
  localparam logic [3:0] ST_SHF  = 4'd9;
  localparam logic [3:0] ST_NSQ  = 4'd10;
  localparam logic [3:0] ST_NRT  = 4'd11;
  localparam logic [3:0] ST_CL   = 4'd12;
  localparam logic [3:0] ST_CLD  = 4'd13;
  localparam logic [3:0] ST_OUT  = 4'd14;

  logic [3:0]  state_r;
  logic [2:0]  idx_r;
  logic [1:0]  cnt_r;
  logic [1:0]  ix;

  logic [REG_W-1:0] avoid_r, nbr_r, sepw_r, maxa_r;
  logic signed [SUM_W-1:0] sum_r [3];

  logic [REG_W-1:0] m_r [3];
  logic             dneg_r [3];
  logic             last_r, five_r, k_r;
  logic [63:0]      sq_r, prod_r;
  logic [71:0]      acc_r;
  logic [31:0]      r_r, n_r;
  logic [FRAC_BITS:0] s_r;
  logic [W_W-1:0]   w_r;
  logic [63:0]      v_r [3];
  logic             out_valid_r;
  logic [POS_W-1:0] out_x_r, out_y_r, out_z_r;

  // square root unit
  logic [63:0] rt_rad_r;
  logic [32:0] rt_rem_r;
  logic [31:0] rt_root_r;
  logic [4:0]  rt_cnt_r;
  logic        rt_busy_r;
  logic [34:0] rt_t, rt_trial;
  logic        rt_ge;

  // divider unit
  logic [31:0] dv_rem_r, dv_q_r, dv_den_r;
  logic [4:0]  dv_cnt_r;
  logic        dv_busy_r;
  logic [32:0] dv_t;
  logic        dv_ge;

  logic [31:0] mul_a, mul_b;

  // input offsets
  logic signed [POS_W:0] dx, dy, dz;
  logic [POS_W:0]        mx, my, mz;
  logic                  use_in;

  logic [SUM_W-1:0]      sum_mag;
  logic signed [SUM_W:0] sat_s;
  logic [SUM_W:0]        sat_c;
  logic [63:0]           sq_sum;
  logic [71:0]           scl_sum;
  logic [W_W-1:0]        wbase;
  logic [63:0]           big;
  logic [REG_W-1:0]      wdiff;
  logic                  out_load;

  assign ix = idx_r[1:0];

  always_comb begin
    dx = {in_self_x[POS_W-1], in_self_x} - {in_other_x[POS_W-1], in_other_x};
    dy = {in_self_y[POS_W-1], in_self_y} - {in_other_y[POS_W-1], in_other_y};
    dz = {in_self_z[POS_W-1], in_self_z} - {in_other_z[POS_W-1], in_other_z};
    mx = dx[POS_W] ? (POS_W+1)'(-dx) : dx;
    my = dy[POS_W] ? (POS_W+1)'(-dy) : dy;
    mz = dz[POS_W] ? (POS_W+1)'(-dz) : dz;
    use_in = !in_is_self && (mx <= {2'b00, nbr_r}) && (my <= {2'b00, nbr_r}) &&
             (mz <= {2'b00, nbr_r});
  end

  always_comb begin
    rt_t     = {rt_rem_r, rt_rad_r[63:62]};
    rt_trial = {1'b0, rt_root_r, 2'b01};
    rt_ge    = rt_t >= rt_trial;
    dv_t     = {dv_rem_r, dv_q_r[31]};
    dv_ge    = dv_t >= {1'b0, dv_den_r};
  end

  always_comb begin
    sum_mag = '0;
    sat_s   = '0;
    sat_c   = '0;
    if (idx_r < 3'd3) begin
      sum_mag = sum_r[ix][SUM_W-1] ? SUM_W'(-sum_r[ix]) : sum_r[ix];
      sat_c   = {{(SUM_W-31){1'b0}}, dv_q_r};
      sat_s   = dneg_r[ix] ? {sum_r[ix][SUM_W-1], sum_r[ix]} - sat_c
                           : {sum_r[ix][SUM_W-1], sum_r[ix]} + sat_c;
    end
    sq_sum  = sq_r + prod_r;
    scl_sum = acc_r + (72'(prod_r) << 32);
    wbase   = W_W'(prod_r >> FRAC_BITS);
    big     = v_r[0] | v_r[1] | v_r[2];
    wdiff   = '0;
    if ({1'b0, avoid_r} > r_r) wdiff = avoid_r - r_r[REG_W-1:0];
    else                       wdiff = nbr_r - r_r[REG_W-1:0];
    out_load = !out_valid_r || out_ready;
  end

  // operand select for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      ST_SQ: begin
        if (idx_r < 3'd3) begin
          mul_a = {1'b0, m_r[ix]};
          mul_b = {1'b0, m_r[ix]};
        end
      end
      ST_WSQ: begin
        mul_a = 32'(s_r);
        mul_b = 32'(s_r);
      end
      ST_CMUL: begin
        if (idx_r < 3'd3) mul_a = {1'b0, m_r[ix]};
        mul_b = 32'(w_r);
      end
      ST_SCL: begin
        mul_a = (cnt_r == 2'd0) ? sum_mag[31:0] : 32'(sum_mag[SUM_W-1:32]);
        mul_b = {1'b0, sepw_r};
      end
      ST_NSQ: begin
        if (idx_r < 3'd3) begin
          mul_a = v_r[ix][31:0];
          mul_b = v_r[ix][31:0];
        end else begin
          mul_a = {1'b0, maxa_r};
          mul_b = {1'b0, maxa_r};
        end
      end
      ST_CL: begin
        if (idx_r < 3'd3) mul_a = v_r[ix][31:0];
        mul_b = {1'b0, maxa_r};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= 64'(mul_a) * 64'(mul_b);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      rt_busy_r   <= 1'b0;
      dv_busy_r   <= 1'b0;
      avoid_r     <= REG_W'(1) << FRAC_BITS;
      nbr_r       <= REG_W'(3) << FRAC_BITS;
      sepw_r      <= REG_W'(1) << FRAC_BITS;
      maxa_r      <= REG_W'(10) << FRAC_BITS;
      sum_r[0]    <= '0;
      sum_r[1]    <= '0;
      sum_r[2]    <= '0;
      idx_r       <= '0;
      cnt_r       <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_addr)
          REG_AVOID: avoid_r <= cfg_wdata;
          REG_NBR:   nbr_r   <= cfg_wdata;
          REG_SEPW:  sepw_r  <= cfg_wdata;
          REG_MAXA:  maxa_r  <= cfg_wdata;
          default:   ;
        endcase
      end

      if (out_valid_r && out_ready) out_valid_r <= 1'b0;

      // square root step: two radicand bits per cycle
      if (rt_busy_r) begin
        rt_rem_r  <= rt_ge ? 33'(rt_t - rt_trial) : rt_t[32:0];
        rt_root_r <= {rt_root_r[30:0], rt_ge};
        rt_rad_r  <= rt_rad_r << 2;
        rt_cnt_r  <= rt_cnt_r + 5'd1;
        if (rt_cnt_r == 5'd31) rt_busy_r <= 1'b0;
      end

      // divide step: one quotient bit per cycle
      if (dv_busy_r) begin
        dv_rem_r <= dv_ge ? 32'(dv_t - {1'b0, dv_den_r}) : dv_t[31:0];
        dv_q_r   <= {dv_q_r[30:0], dv_ge};
        dv_cnt_r <= dv_cnt_r + 5'd1;
        if (dv_cnt_r == 5'd31) dv_busy_r <= 1'b0;
      end

      unique case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            m_r[0]  <= mx[REG_W-1:0];
            m_r[1]  <= my[REG_W-1:0];
            m_r[2]  <= mz[REG_W-1:0];
            dneg_r[0] <= dx[POS_W];
            dneg_r[1] <= dy[POS_W];
            dneg_r[2] <= dz[POS_W];
            last_r  <= in_last_item;
            sq_r    <= '0;
            idx_r   <= '0;
            cnt_r   <= '0;
            if (use_in)            state_r <= ST_SQ;
            else if (in_last_item) state_r <= ST_SCL;
          end
        end
        ST_SQ: begin
          idx_r <= idx_r + 3'd1;
          if (idx_r != 3'd0) sq_r <= sq_sum;
          if (idx_r == 3'd3) begin
            if (sq_sum == '0) begin
              idx_r   <= '0;
              state_r <= last_r ? ST_SCL : ST_IDLE;
            end else begin
              rt_rad_r  <= sq_sum;
              rt_rem_r  <= '0;
              rt_root_r <= '0;
              rt_cnt_r  <= '0;
              rt_busy_r <= 1'b1;
              state_r   <= ST_RT;
            end
          end
        end
        ST_RT: begin
          if (!rt_busy_r) begin
            r_r     <= rt_root_r;
            state_r <= ST_WSEL;
          end
        end
        ST_WSEL: begin
          idx_r <= '0;
          cnt_r <= '0;
          if (r_r > {1'b0, nbr_r} ||
              (r_r >= {1'b0, avoid_r} && nbr_r <= avoid_r)) begin
            state_r <= last_r ? ST_SCL : ST_IDLE;
          end else begin
            five_r    <= {1'b0, avoid_r} > r_r;
            dv_rem_r  <= 32'((64'(wdiff) << FRAC_BITS) >> 32);
            dv_q_r    <= 32'(64'(wdiff) << FRAC_BITS);
            dv_den_r  <= ({1'b0, avoid_r} > r_r) ? {1'b0, avoid_r}
                                                 : {1'b0, nbr_r - avoid_r};
            dv_cnt_r  <= '0;
            dv_busy_r <= 1'b1;
            state_r   <= ST_WDIV;
          end
        end
        ST_WDIV: begin
          if (!dv_busy_r) begin
            s_r     <= dv_q_r[FRAC_BITS:0];
            cnt_r   <= '0;
            state_r <= ST_WSQ;
          end
        end
        ST_WSQ: begin
          cnt_r <= cnt_r + 2'd1;
          if (cnt_r == 2'd1) begin
            w_r     <= five_r ? W_W'((wbase << 2) + wbase) : wbase;
            idx_r   <= '0;
            cnt_r   <= '0;
            state_r <= ST_CMUL;
          end
        end
        ST_CMUL: begin
          cnt_r <= cnt_r + 2'd1;
          if (cnt_r == 2'd1) begin
            dv_rem_r  <= prod_r[63:32];
            dv_q_r    <= prod_r[31:0];
            dv_den_r  <= r_r;
            dv_cnt_r  <= '0;
            dv_busy_r <= 1'b1;
            state_r   <= ST_CDIV;
          end
        end
        ST_CDIV: begin
          if (!dv_busy_r) begin
            // saturate on the two top bits disagreeing
            if (sat_s[SUM_W] != sat_s[SUM_W-1])
              sum_r[ix] <= sat_s[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}}
                                        : {1'b0, {(SUM_W-1){1'b1}}};
            else
              sum_r[ix] <= sat_s[SUM_W-1:0];
            cnt_r <= '0;
            if (idx_r == 3'd2) begin
              idx_r   <= '0;
              state_r <= last_r ? ST_SCL : ST_IDLE;
            end else begin
              idx_r   <= idx_r + 3'd1;
              state_r <= ST_CMUL;
            end
          end
        end
        ST_SCL: begin
          cnt_r <= cnt_r + 2'd1;
          if (cnt_r == 2'd1) acc_r <= 72'(prod_r);
          if (cnt_r == 2'd2) begin
            v_r[ix] <= 64'(scl_sum >> FRAC_BITS);
            cnt_r   <= '0;
            if (idx_r == 3'd2) begin
              k_r     <= 1'b0;
              state_r <= ST_SHF;
            end
            idx_r <= (idx_r == 3'd2) ? 3'd0 : idx_r + 3'd1;
          end
        end
        ST_SHF: begin
          if (big[63:31] != '0) begin
            v_r[0] <= v_r[0] >> 1;
            v_r[1] <= v_r[1] >> 1;
            v_r[2] <= v_r[2] >> 1;
            k_r    <= 1'b1;
          end else begin
            sq_r    <= '0;
            idx_r   <= '0;
            state_r <= ST_NSQ;
          end
        end
        ST_NSQ: begin
          idx_r <= idx_r + 3'd1;
          if (idx_r != 3'd0 && idx_r != 3'd4) sq_r <= sq_sum;
          if (idx_r == 3'd4) begin
            idx_r <= '0;
            cnt_r <= '0;
            // prod_r holds the squared limit here
            if (k_r || sq_r > prod_r) begin
              rt_rad_r  <= sq_r;
              rt_rem_r  <= '0;
              rt_root_r <= '0;
              rt_cnt_r  <= '0;
              rt_busy_r <= 1'b1;
              state_r   <= ST_NRT;
            end else begin
              state_r <= ST_OUT;
            end
          end
        end
        ST_NRT: begin
          if (!rt_busy_r) begin
            n_r     <= rt_root_r;
            state_r <= ST_CL;
          end
        end
        ST_CL: begin
          cnt_r <= cnt_r + 2'd1;
          if (cnt_r == 2'd1) begin
            dv_rem_r  <= prod_r[63:32];
            dv_q_r    <= prod_r[31:0];
            dv_den_r  <= n_r;
            dv_cnt_r  <= '0;
            dv_busy_r <= 1'b1;
            state_r   <= ST_CLD;
          end
        end
        ST_CLD: begin
          if (!dv_busy_r) begin
            v_r[ix] <= 64'(dv_q_r);
            cnt_r   <= '0;
            if (idx_r == 3'd2) begin
              idx_r   <= '0;
              state_r <= ST_OUT;
            end else begin
              idx_r   <= idx_r + 3'd1;
              state_r <= ST_CL;
            end
          end
        end
        ST_OUT: begin
          // hold until the output register is free
          if (out_load) begin
            out_x_r     <= sum_r[0][SUM_W-1] ? -v_r[0][31:0] : v_r[0][31:0];
            out_y_r     <= sum_r[1][SUM_W-1] ? -v_r[1][31:0] : v_r[1][31:0];
            out_z_r     <= sum_r[2][SUM_W-1] ? -v_r[2][31:0] : v_r[2][31:0];
            out_valid_r <= 1'b1;
            sum_r[0]    <= '0;
            sum_r[1]    <= '0;
            sum_r[2]    <= '0;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign in_ready    = (state_r == ST_IDLE);
  assign out_valid   = out_valid_r;
  assign out_accel_x = out_x_r;
  assign out_accel_y = out_y_r;
  assign out_accel_z = out_z_r;

  a_units_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(rt_busy_r && dv_busy_r))
    else $error("root and divide units busy together");

  a_idle_units_free: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> (!rt_busy_r && !dv_busy_r))
    else $error("input taken while an arithmetic unit is busy");

  a_emit_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_OUT && out_load) |=>
      (out_valid && sum_r[0] == '0 && sum_r[1] == '0 && sum_r[2] == '0))
    else $error("result emitted without clearing the accumulators");

endmodule

`default_nettype wire
